>>> hw/rtl/cbsru_pkg.sv
`default_nettype none

package cbsru_pkg;

    localparam int DATA_W   = 8;
    localparam int SEL_W    = 3;
    localparam int FLAG_W   = 4;
    localparam int ADDR_W   = 16;
    localparam int CYC_W    = 5;
    localparam int NUM_REGS = 7;

    localparam logic [SEL_W-1:0]  SEL_H      = 3'd4;
    localparam logic [SEL_W-1:0]  SEL_L      = 3'd5;
    localparam logic [SEL_W-1:0]  SEL_MEM    = 3'd6;
    localparam logic [SEL_W-1:0]  SEL_FLAGS  = 3'd6;
    localparam logic [SEL_W-1:0]  SEL_A      = 3'd7;
    localparam logic [SEL_W-1:0]  SLOT_A     = 3'd6;

    localparam logic [DATA_W-1:0] OP_LAST    = 8'h57;
    localparam logic [DATA_W-1:0] OP_BIT_LO  = 8'h40;

    localparam logic [CYC_W-1:0]  CYC_NONE   = 5'd0;
    localparam logic [CYC_W-1:0]  CYC_REG    = 5'd8;
    localparam logic [CYC_W-1:0]  CYC_MEM    = 5'd16;

    localparam int FLAG_Z_BIT = 3;
    localparam int FLAG_N_BIT = 2;
    localparam int FLAG_H_BIT = 1;
    localparam int FLAG_C_BIT = 0;

    typedef enum logic [2:0] {
        SK_RLC  = 3'd0,
        SK_RRC  = 3'd1,
        SK_RL   = 3'd2,
        SK_RR   = 3'd3,
        SK_SLA  = 3'd4,
        SK_SRA  = 3'd5,
        SK_SWAP = 3'd6,
        SK_SRL  = 3'd7
    } t_shift_kind;

    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic              cout;
    } t_shift_res;

    function automatic logic [SEL_W-1:0] slot_of(input logic [SEL_W-1:0] sel);
        slot_of = (sel == SEL_A) ? SLOT_A : sel;
    endfunction

    function automatic t_shift_res shift_op(input t_shift_kind kind,
                                           input logic [DATA_W-1:0] x,
                                           input logic cin);
        t_shift_res res;
        res = '0;
        unique case (kind)
            SK_RLC: begin
                res.cout  = x[7];
                res.value = {x[6:0], x[7]};
            end
            SK_RRC: begin
                res.cout  = x[0];
                res.value = {x[0], x[7:1]};
            end
            SK_RL: begin
                res.cout  = x[7];
                res.value = {x[6:0], cin};
            end
            SK_RR: begin
                res.cout  = x[0];
                res.value = {cin, x[7:1]};
            end
            SK_SLA: begin
                res.cout  = x[7];
                res.value = {x[6:0], 1'b0};
            end
            SK_SRA: begin
                res.cout  = x[0];
                res.value = {x[7], x[7:1]};
            end
            SK_SWAP: begin
                res.cout  = 1'b0;
                res.value = {x[3:0], x[7:4]};
            end
            SK_SRL: begin
                res.cout  = x[0];
                res.value = {1'b0, x[7:1]};
            end
            default: begin
                res = '0;
            end
        endcase
        shift_op = res;
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/cb_shift_rotate_bit_unit.sv
// timing: the result beat is registered at the edge that accepts the input beat
// throughput: one beat per cycle while i_out_ready is high; each opcode is
// one pass through the shift and bit-test logic into the result register,
// with the register file and flags updated at the same edge
// reset: synchronous active-low; registers B-A and flags ZNHC cleared to zero
`default_nettype none

module cb_shift_rotate_bit_unit
    import cbsru_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire logic [DATA_W-1:0] i_opcode,
    input  wire logic [DATA_W-1:0] i_memory_byte,
    input  wire logic              i_preload_enable,
    input  wire logic [SEL_W-1:0]  i_preload_index,
    input  wire logic [DATA_W-1:0] i_preload_value,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output logic [DATA_W-1:0]      o_result_byte,
    output logic [SEL_W-1:0]       o_target_index,
    output logic                   o_write_memory,
    output logic [ADDR_W-1:0]      o_memory_address,
    output logic [FLAG_W-1:0]      o_flags_out,
    output logic                   o_op_valid,
    output logic [CYC_W-1:0]       o_cycle_count
);

    logic [DATA_W-1:0] r_regs [NUM_REGS];
    logic [DATA_W-1:0] n_regs [NUM_REGS];
    logic [FLAG_W-1:0] r_flags;
    logic [FLAG_W-1:0] n_flags;

    logic              r_out_valid;
    logic [DATA_W-1:0] r_result;
    logic [SEL_W-1:0]  r_target;
    logic              r_wmem;
    logic [ADDR_W-1:0] r_addr;
    logic              r_op_valid;
    logic [CYC_W-1:0]  r_cycles;

    logic [DATA_W-1:0] n_result;
    logic [SEL_W-1:0]  n_target;
    logic              n_wmem;
    logic              n_op_valid;
    logic [CYC_W-1:0]  n_cycles;

    logic              accept;
    logic [SEL_W-1:0]  sel;
    logic              is_mem;
    logic [DATA_W-1:0] operand;
    t_shift_res        sres;
    logic              bitv;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;

    assign sel     = i_opcode[2:0];
    assign is_mem  = (sel == SEL_MEM);
    assign operand = is_mem ? i_memory_byte : r_regs[slot_of(sel)];
    assign sres    = shift_op(t_shift_kind'(i_opcode[5:3]), operand,
                              r_flags[FLAG_C_BIT]);
    assign bitv    = operand[i_opcode[5:3]];

    always_comb begin
        n_regs     = r_regs;
        n_flags    = r_flags;
        n_result   = '0;
        n_target   = '0;
        n_wmem     = 1'b0;
        n_op_valid = 1'b0;
        n_cycles   = CYC_NONE;
        if (i_preload_enable) begin
            if (i_preload_index == SEL_FLAGS) begin
                n_flags = i_preload_value[7:4];
            end else begin
                n_regs[slot_of(i_preload_index)] = i_preload_value;
            end
            n_result = i_preload_value;
            n_target = i_preload_index;
        end else if (i_opcode <= OP_LAST) begin
            n_target   = sel;
            n_op_valid = 1'b1;
            n_cycles   = is_mem ? CYC_MEM : CYC_REG;
            if (i_opcode < OP_BIT_LO) begin
                n_result                = sres.value;
                n_flags                 = '0;
                n_flags[FLAG_Z_BIT]     = (sres.value == '0);
                n_flags[FLAG_C_BIT]     = sres.cout;
                if (is_mem) begin
                    n_wmem = 1'b1;
                end else begin
                    n_regs[slot_of(sel)] = sres.value;
                end
            end else begin
                n_result            = operand;
                n_flags[FLAG_Z_BIT] = !bitv;
                n_flags[FLAG_N_BIT] = 1'b0;
                n_flags[FLAG_H_BIT] = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_REGS; i++) begin
                r_regs[i] <= '0;
            end
            r_flags     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_regs      <= n_regs;
                r_flags     <= n_flags;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result beat payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_result   <= n_result;
            r_target   <= n_target;
            r_wmem     <= n_wmem;
            r_addr     <= {n_regs[SEL_H], n_regs[SEL_L]};
            r_op_valid <= n_op_valid;
            r_cycles   <= n_cycles;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_result_byte    = r_result;
    assign o_target_index   = r_target;
    assign o_write_memory   = r_wmem;
    assign o_memory_address = r_addr;
    assign o_flags_out      = r_flags;
    assign o_op_valid       = r_op_valid;
    assign o_cycle_count    = r_cycles;

`ifndef SYNTHESIS
    a_wmem_only_mem_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_write_memory) |->
            (o_op_valid && o_target_index == SEL_MEM && o_cycle_count == CYC_MEM))
        else $error("memory write without a valid (HL) opcode");

    a_invalid_no_cycles: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_op_valid) |-> (o_cycle_count == CYC_NONE && !o_write_memory))
        else $error("non-executed beat reports cycles or a memory write");

    a_cycles_match_operand: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_op_valid) |->
            ((o_cycle_count == CYC_MEM) == (o_target_index == SEL_MEM)))
        else $error("cycle count does not match operand kind");

    a_preload_h_visible: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_preload_enable && i_preload_index == SEL_H) |=>
            (o_memory_address[15:8] == $past(i_preload_value)))
        else $error("preload of H not reflected in address");

    a_bit_sets_h: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_op_valid && !o_write_memory && o_flags_out[FLAG_H_BIT]) |->
            !o_flags_out[FLAG_N_BIT])
        else $error("bit test left N set");
`endif

endmodule

`default_nettype wire
